// ===== rtl/lsnc_pkg.sv =====
// Shared types, constants and helpers for the scan nearest-cluster block.
package lsnc_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [CsrAddrWidth-1:0] CSR_MIN_DISTANCE   = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_MIN_QUALITY    = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_CLUSTER_DIST   = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_CLUSTER_ANGLE  = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_CLUSTER_POINTS = 3'd4;
   localparam logic [CsrAddrWidth-1:0] CSR_BACKWARD_LIMIT = 3'd5;
   localparam logic [CsrAddrWidth-1:0] CSR_FORWARD_LIMIT  = 3'd6;

   localparam logic [15:0] RST_MIN_DISTANCE   = 16'd320;
   localparam logic [5:0]  RST_MIN_QUALITY    = 6'd10;
   localparam logic [15:0] RST_CLUSTER_DIST   = 16'd200;
   localparam logic [13:0] RST_CLUSTER_ANGLE  = 14'd320;
   localparam logic [7:0]  RST_CLUSTER_POINTS = 8'd3;
   localparam logic [13:0] RST_BACKWARD_LIMIT = 14'd128;
   localparam logic [13:0] RST_FORWARD_LIMIT  = 14'd1280;

   // 360 degrees and 180 degrees in 1/64 degree
   localparam logic [14:0]        FULL_TURN_U = 15'd23040;
   localparam logic signed [15:0] FULL_TURN   = 16'sd23040;
   localparam logic signed [15:0] HALF_TURN   = 16'sd11520;

   localparam logic [15:0] NO_DISTANCE = 16'hFFFF;
   localparam logic [7:0]  COUNT_MAX   = 8'hFF;

   typedef struct packed {
      logic [15:0] min_distance;
      logic [5:0]  min_quality;
      logic [15:0] cluster_distance_tolerance;
      logic [13:0] cluster_angle_tolerance;
      logic [7:0]  cluster_min_points;
      logic [13:0] backward_step_limit;
      logic [13:0] forward_step_limit;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic        start;
      logic [14:0] angle;
      logic [15:0] distance;
      logic [5:0]  qual;
   } pkt_type;

   typedef struct packed {
      logic emit;
      logic take;
   } trk_ctl_type;

   typedef struct packed {
      logic [14:0] best_angle;
      logic [15:0] best_distance;
      logic [5:0]  best_quality;
      logic        best_found;
      logic [7:0]  coherent_count;
   } trk_status_type;

   // fold an angle difference into [-half turn, half turn]
   function automatic logic signed [15:0] wrap_gap(input logic signed [15:0] d);
      logic signed [15:0] r;
      r = d;
      if (d < -HALF_TURN) begin
         r = d + FULL_TURN;
      end else if (d > HALF_TURN) begin
         r = d - FULL_TURN;
      end
      return r;
   endfunction

endpackage

// ===== rtl/lsnc_csr.sv =====
// Configuration register file with write-only access.
module lsnc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lsnc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [lsnc_pkg::CsrDataWidth-1:0]   csr_wdata,
   output lsnc_pkg::cfg_type                   cfg
);
   import lsnc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MIN_DISTANCE:   cfg_in.min_distance = csr_wdata;
            CSR_MIN_QUALITY:    cfg_in.min_quality = csr_wdata[5:0];
            CSR_CLUSTER_DIST:   cfg_in.cluster_distance_tolerance = csr_wdata;
            CSR_CLUSTER_ANGLE:  cfg_in.cluster_angle_tolerance = csr_wdata[13:0];
            CSR_CLUSTER_POINTS: cfg_in.cluster_min_points = csr_wdata[7:0];
            CSR_BACKWARD_LIMIT: cfg_in.backward_step_limit = csr_wdata[13:0];
            CSR_FORWARD_LIMIT:  cfg_in.forward_step_limit = csr_wdata[13:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance               <= RST_MIN_DISTANCE;
         cfg_ff.min_quality                <= RST_MIN_QUALITY;
         cfg_ff.cluster_distance_tolerance <= RST_CLUSTER_DIST;
         cfg_ff.cluster_angle_tolerance    <= RST_CLUSTER_ANGLE;
         cfg_ff.cluster_min_points         <= RST_CLUSTER_POINTS;
         cfg_ff.backward_step_limit        <= RST_BACKWARD_LIMIT;
         cfg_ff.forward_step_limit         <= RST_FORWARD_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lsnc_packet.sv =====
// Byte window and packet framing: start-bit checks and field extraction.
module lsnc_packet (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               clear,
   input  logic [7:0]         data_byte,
   output lsnc_pkg::pkt_type  pkt
);
   import lsnc_pkg::*;

   logic [7:0]  win_ff [4];
   logic [7:0]  win_in [4];
   logic [14:0] raw_angle;

   always_comb begin
      win_in = win_ff;
      if (shift) begin
         if (clear) begin
            for (int i = 0; i < 4; i++) begin
               win_in[i] = 8'd0;
            end
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            win_in[3] = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   assign raw_angle = {win_ff[2], win_ff[1][7:1]};

   always_comb begin
      pkt.hit      = (win_ff[0][0] ^ win_ff[0][1]) & win_ff[1][0];
      pkt.start    = win_ff[0][0];
      pkt.angle    = (raw_angle >= FULL_TURN_U) ? raw_angle - FULL_TURN_U : raw_angle;
      pkt.distance = {data_byte, win_ff[3]};
      pkt.qual     = win_ff[0][7:2];
   end

endmodule

// ===== rtl/lsnc_tracker.sv =====
// Angle step check, cluster filter and nearest-point tracking.
module lsnc_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  lsnc_pkg::cfg_type           cfg,
   input  lsnc_pkg::pkt_type           pkt,
   output lsnc_pkg::trk_ctl_type       ctl,
   output lsnc_pkg::trk_status_type    status
);
   import lsnc_pkg::*;

   logic [14:0] sync_angle_ff, sync_angle_in;
   logic        sync_armed_ff, sync_armed_in;
   logic [15:0] best_dist_ff, best_dist_in;
   logic [14:0] best_angle_ff, best_angle_in;
   logic [5:0]  best_qual_ff, best_qual_in;
   logic        best_found_ff, best_found_in;
   logic [15:0] obj_dist_ff, obj_dist_in;
   logic [14:0] obj_angle_ff, obj_angle_in;
   logic [7:0]  count_ff, count_in;

   logic signed [15:0] step, agap_s;
   logic signed [16:0] dgap_s;
   logic [15:0]        agap, dgap;
   logic               drop, take, pass, match, counts, better;
   logic [7:0]         count_base, count_new;
   logic               found_base;
   logic [15:0]        dist_base;

   always_comb begin
      step = wrap_gap($signed({1'b0, pkt.angle}) - $signed({1'b0, sync_angle_ff}));
      drop = sync_armed_ff && !pkt.start &&
             ((step < -$signed({2'b00, cfg.backward_step_limit})) ||
              (step > $signed({2'b00, cfg.forward_step_limit})));
      take = pkt.hit && !drop;

      // revolution start wipes the running best before the point is scored
      count_base = pkt.start ? 8'd0 : count_ff;
      found_base = pkt.start ? 1'b0 : best_found_ff;
      dist_base  = pkt.start ? NO_DISTANCE : best_dist_ff;

      pass   = (pkt.distance > cfg.min_distance) && (pkt.qual > cfg.min_quality);
      agap_s = wrap_gap($signed({1'b0, pkt.angle}) - $signed({1'b0, obj_angle_ff}));
      dgap_s = $signed({1'b0, pkt.distance}) - $signed({1'b0, obj_dist_ff});
      agap   = agap_s[15] ? 16'(-agap_s) : 16'(agap_s);
      dgap   = dgap_s[16] ? 16'(-dgap_s) : 16'(dgap_s);
      match  = (dgap < cfg.cluster_distance_tolerance) &&
               (agap < {2'b00, cfg.cluster_angle_tolerance});
      if (match) begin
         count_new = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 8'd1;
      end else begin
         count_new = 8'd1;
      end
      counts = count_new >= cfg.cluster_min_points;
      better = !found_base || (pkt.distance < dist_base);
   end

   always_comb begin
      sync_angle_in = sync_angle_ff;
      sync_armed_in = sync_armed_ff;
      best_dist_in  = best_dist_ff;
      best_angle_in = best_angle_ff;
      best_qual_in  = best_qual_ff;
      best_found_in = best_found_ff;
      obj_dist_in   = obj_dist_ff;
      obj_angle_in  = obj_angle_ff;
      count_in      = count_ff;
      if (advance && pkt.hit) begin
         if (drop) begin
            sync_armed_in = 1'b0;
         end else begin
            sync_angle_in = pkt.angle;
            sync_armed_in = 1'b1;
            count_in      = count_base;
            best_found_in = found_base;
            best_dist_in  = dist_base;
            if (pass) begin
               count_in     = count_new;
               obj_dist_in  = pkt.distance;
               obj_angle_in = pkt.angle;
               if (counts && better) begin
                  best_dist_in  = pkt.distance;
                  best_angle_in = pkt.angle;
                  best_qual_in  = pkt.qual;
                  best_found_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_angle_ff <= '0;
         sync_armed_ff <= 1'b0;
         best_dist_ff  <= NO_DISTANCE;
         best_angle_ff <= '0;
         best_qual_ff  <= '0;
         best_found_ff <= 1'b0;
         obj_dist_ff   <= '0;
         obj_angle_ff  <= '0;
         count_ff      <= '0;
      end else begin
         sync_angle_ff <= sync_angle_in;
         sync_armed_ff <= sync_armed_in;
         best_dist_ff  <= best_dist_in;
         best_angle_ff <= best_angle_in;
         best_qual_ff  <= best_qual_in;
         best_found_ff <= best_found_in;
         obj_dist_ff   <= obj_dist_in;
         obj_angle_ff  <= obj_angle_in;
         count_ff      <= count_in;
      end
   end

   assign ctl.take = take;
   assign ctl.emit = take && pkt.start;

   assign status.best_angle     = best_angle_ff;
   assign status.best_distance  = best_dist_ff;
   assign status.best_quality   = best_qual_ff;
   assign status.best_found     = best_found_ff;
   assign status.coherent_count = count_ff;

endmodule

// ===== rtl/lidar_scan_nearest_cluster.sv =====
// Top level: input byte register, packet/cluster logic, result register.
// Bytes are registered on input; a report is registered as its byte is scored.
// Throughput: one byte per cycle; the only stall is a revolution-start packet
// that meets a result still waiting in the output register.
// Reset (synchronous, active high) clears the window, tracking state, config
// registers to defaults, and both valid flags; payload registers are not reset.
module lidar_scan_nearest_cluster (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [lsnc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [lsnc_pkg::CsrDataWidth-1:0]   csr_wdata,
   // byte stream in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   // nearest-point result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] nearest_angle, [30:15] nearest_distance, [36:31] nearest_quality,
   // [39:37] zero
   output logic [39:0]                         rsp_tdata,
   output logic                                rsp_tuser    // [0] point_found
);
   import lsnc_pkg::*;

   cfg_type        cfg;
   pkt_type        pkt;
   trk_ctl_type    ctl;
   trk_status_type status;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff, out_data_in;
   logic        out_user_ff, out_user_in;

   logic out_free, advance, load;

   lsnc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lsnc_packet u_packet (
      .clock     (clock),
      .reset     (reset),
      .shift     (advance),
      .clear     (advance && ctl.take),
      .data_byte (in_byte_ff),
      .pkt       (pkt)
   );

   lsnc_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .pkt     (pkt),
      .ctl     (ctl),
      .status  (status)
   );

   // The held byte moves on unless it would emit while the result slot is busy.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!ctl.emit || out_free);
   assign load       = advance && ctl.emit;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   // Result carries the best point from before this packet's own point.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_data_in  = {3'b000, status.best_quality, status.best_distance,
                         status.best_angle};
         out_user_in  = status.best_found;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // no best point held means the distance sits at its empty value
   a_empty_best: assert property (@(posedge clock) disable iff (reset)
      !status.best_found |-> status.best_distance == NO_DISTANCE)
      else $error("best distance not empty while no point held");

   // a held point implies the cluster count has started
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      status.best_found |-> status.coherent_count != 8'd0)
      else $error("best point held with zero cluster count");

   // a stalled input byte stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input stage lost a stalled byte");

   // a pending result is never overwritten by a new one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !load)
      else $error("result register overwritten while pending");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for lidar_scan_nearest_cluster: sensor byte stream in, nearest-point results scored.
module tb_top;
   import lsnc_pkg::*;

   localparam int TURN = 23040;          // 360 deg in 1/64 deg
   localparam int HALF = 11520;          // 180 deg
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_BYTES = 1320;
   localparam int PHASES = 10;
   localparam int PRESSURE_PHASE = 5;

   // one nearest-point report, as the block sends it
   typedef struct packed {
      logic [14:0] angle;
      logic [15:0] distance;
      logic [5:0]  qual;
      logic        found;
   } nearest_type;

   // one directed packet; want is only meaningful when typed is set
   typedef struct packed {
      logic        start;
      logic [5:0]  qual;
      logic [14:0] raw_angle;
      logic [15:0] distance;
      logic        typed;
      nearest_type want;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [39:0]             rsp_tdata;
   logic                    rsp_tuser;

   lidar_scan_nearest_cluster dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------
   // Local copy of the block's state and registers
   // ---------------------------------------------------------------
   cfg_type     regs_now;
   logic [7:0]  window_q [4];
   logic [14:0] lock_angle;         // angle of the last accepted packet
   logic        lock_armed;         // step check active
   nearest_type best_q;             // running nearest point of this revolution
   logic [15:0] obj_dist;
   logic [14:0] obj_angle;
   logic [7:0]  run_count;          // coherent points in a row, saturating

   nearest_type nearest_due [$];    // reports still owed by the block
   logic [39:0] last_data;
   logic        last_user;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;
   bit          gaps_on = 1'b1;
   bit          hold_req = 1'b0;
   int          sweep_angle = 0;
   int          sweep_dist = 1000;

   // Directed packets. Typed rows carry a report readable straight off the spec:
   // first start after reset, a clean revolution, and a start right after a start.
   row_type dir_rows [17] = '{
      // start, qual, raw angle, distance, typed, expected report
      '{1'b1, 6'd20, 15'd0,     16'd1000,  1'b1, '{15'd0,   16'hFFFF, 6'd0,  1'b0}},
      '{1'b0, 6'd20, 15'd64,    16'd1000,  1'b0, '0},
      '{1'b0, 6'd63, 15'd128,   16'd1010,  1'b0, '0},
      '{1'b0, 6'd30, 15'd192,   16'd1020,  1'b0, '0},   // fourth coherent point, not nearer: best kept
      '{1'b0, 6'd40, 15'd256,   16'd1005,  1'b0, '0},   // nearer, replaces best
      '{1'b1, 6'd20, 15'd300,   16'd2000,  1'b1, '{15'd256, 16'd1005, 6'd40, 1'b1}},
      '{1'b1, 6'd11, 15'd310,   16'd2100,  1'b1, '{15'd256, 16'hFFFF, 6'd40, 1'b0}},
      '{1'b0, 6'd20, 15'd2000,  16'd1000,  1'b0, '0},   // forward step too large: dropped
      '{1'b0, 6'd0,  15'd32767, 16'd0,     1'b0, '0},   // raw angle past a full turn
      '{1'b1, 6'd63, 15'd23039, 16'hFFFF,  1'b0, '0},
      '{1'b0, 6'd63, 15'd100,   16'hFFFF,  1'b0, '0},   // forward across zero
      '{1'b0, 6'd63, 15'd23000, 16'd65500, 1'b0, '0},   // backward across zero, too far
      '{1'b1, 6'd10, 15'd200,   16'd320,   1'b0, '0},   // exactly at both thresholds
      '{1'b0, 6'd11, 15'd200,   16'd321,   1'b0, '0},   // just above, zero step
      '{1'b0, 6'd11, 15'd72,    16'd330,   1'b0, '0},   // backward step at the limit
      '{1'b0, 6'd11, 15'd1352,  16'd340,   1'b0, '0},   // forward step at the limit
      '{1'b1, 6'd0,  15'd0,     16'd0,     1'b0, '0}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   // fold an angle difference into [-half turn, half turn]
   function automatic int fold_angle(input int d);
      if (d < -HALF) return d + TURN;
      if (d > HALF) return d - TURN;
      return d;
   endfunction

   // Advance the local copy by one received byte; queue a report on a start packet.
   function automatic void score_byte(input logic [7:0] b);
      logic [7:0] w0, w1, w2, w3;
      int angle, distance, qual, step, agap, dgap;
      w0 = window_q[0];
      w1 = window_q[1];
      w2 = window_q[2];
      w3 = window_q[3];
      window_q[0] = w1;
      window_q[1] = w2;
      window_q[2] = w3;
      window_q[3] = b;
      if ((w0[0] ^ w0[1]) && w1[0]) begin
         angle    = int'({w2, w1[7:1]}) % TURN;
         distance = int'({b, w3});
         qual     = int'(w0[7:2]);
         // step check only between tracking packets; a drop keeps the window
         if (lock_armed && !w0[0]) begin
            step = fold_angle(angle - int'(lock_angle));
            if (step < -int'(regs_now.backward_step_limit) ||
                step > int'(regs_now.forward_step_limit)) begin
               lock_armed = 1'b0;
               return;
            end
         end
         lock_angle = 15'(angle);
         lock_armed = 1'b1;
         if (w0[0]) begin
            // revolution start: report what was held, then begin afresh
            nearest_due.push_back(best_q);
            best_q.distance = NO_DISTANCE;
            best_q.found    = 1'b0;
            run_count       = '0;
         end
         if (distance > int'(regs_now.min_distance) &&
             qual > int'(regs_now.min_quality)) begin
            agap = fold_angle(angle - int'(obj_angle));
            dgap = distance - int'(obj_dist);
            if (agap < 0) agap = -agap;
            if (dgap < 0) dgap = -dgap;
            if (dgap < int'(regs_now.cluster_distance_tolerance) &&
                agap < int'(regs_now.cluster_angle_tolerance)) begin
               if (run_count != COUNT_MAX) run_count = run_count + 8'd1;
            end else begin
               run_count = 8'd1;
            end
            obj_dist  = 16'(distance);
            obj_angle = 15'(angle);
            if (run_count >= regs_now.cluster_min_points) begin
               if (!best_q.found || distance < int'(best_q.distance)) begin
                  best_q = '{15'(angle), 16'(distance), 6'(qual), 1'b1};
               end
            end
         end
         foreach (window_q[i]) window_q[i] = '0;
      end
   endfunction

   function automatic void check_nearest(input nearest_type want, input logic [39:0] data,
                                         input logic user);
      if (data[14:0] !== want.angle) begin
         $display("%0t nearest_angle: expected %0d, actual %0d", $time, want.angle, data[14:0]);
         mismatches++;
      end
      if (data[30:15] !== want.distance) begin
         $display("%0t nearest_distance: expected %0d, actual %0d", $time, want.distance,
                  data[30:15]);
         mismatches++;
      end
      if (data[36:31] !== want.qual) begin
         $display("%0t nearest_quality: expected %0d, actual %0d", $time, want.qual,
                  data[36:31]);
         mismatches++;
      end
      if (data[39:37] !== 3'b000) begin
         $display("%0t rsp_tdata pad: expected 0, actual %b", $time, data[39:37]);
         mismatches++;
      end
      if (user !== want.found) begin
         $display("%0t point_found: expected %b, actual %b", $time, want.found, user);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Monitor: both channels sampled at the edge, model runs first
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) score_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            last_data = rsp_tdata;
            last_user = rsp_tuser;
            if (nearest_due.size() == 0) begin
               $display("%0t unexpected report: expected none, actual %h / %b", $time,
                        rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               check_nearest(nearest_due.pop_front(), rsp_tdata, rsp_tuser);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // no transfer on either side for too long: give up
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // Receiver: short random stalls, one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // One byte transfer, optionally after a short idle burst.
   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Five-byte measurement packet; cut < 5 sends a truncated one.
   task automatic send_packet(input logic start, input logic [5:0] qual,
                              input logic [14:0] raw_angle, input logic [15:0] distance,
                              input int cut);
      logic [7:0] pkt [5];
      pkt[0] = {qual, ~start, start};
      pkt[1] = {raw_angle[6:0], 1'b1};
      pkt[2] = raw_angle[14:7];
      pkt[3] = distance[7:0];
      pkt[4] = distance[15:8];
      for (int k = 0; k < cut; k++) send_byte(pkt[k]);
   endtask

   // Stop offering, collect every owed report, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (nearest_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // All seven registers; junk above the narrow fields must be ignored.
   task automatic load_regs(input cfg_type c);
      write_reg(CSR_MIN_DISTANCE, c.min_distance);
      write_reg(CSR_MIN_QUALITY, {10'($urandom), c.min_quality});
      write_reg(CSR_CLUSTER_DIST, c.cluster_distance_tolerance);
      write_reg(CSR_CLUSTER_ANGLE, {2'($urandom), c.cluster_angle_tolerance});
      write_reg(CSR_CLUSTER_POINTS, {8'($urandom), c.cluster_min_points});
      write_reg(CSR_BACKWARD_LIMIT, {2'($urandom), c.backward_step_limit});
      write_reg(CSR_FORWARD_LIMIT, {2'($urandom), c.forward_step_limit});
      csr_we <= 1'b0;
      regs_now = c;
   endtask

   // mostly a working value, sometimes zero or the top of the field
   function automatic int pick_setting(input int typical_hi, input int top);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return top;
         default: return int'($urandom_range(0, typical_hi));
      endcase
   endfunction

   // A start packet and n_pts tracking packets: a sweep with jitter, plus
   // occasional line noise, wild jumps and truncated packets.
   task automatic run_revolution(input int n_pts);
      int step, raw, q, cut;
      for (int j = 0; j <= n_pts; j++) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
         case ($urandom_range(0, 9))
            0: step = -int'($urandom_range(0, 400));
            1: step = int'($urandom_range(0, TURN - 1));
            default: step = int'($urandom_range(0, 250));
         endcase
         sweep_angle = (sweep_angle + step + TURN) % TURN;
         raw = sweep_angle;
         if ($urandom_range(0, 15) == 0 && sweep_angle + TURN <= 32767) raw = sweep_angle + TURN;
         case ($urandom_range(0, 9))
            0: sweep_dist = int'($urandom_range(0, 65535));
            1: sweep_dist = int'(regs_now.min_distance) + int'($urandom_range(0, 1));
            default: sweep_dist = sweep_dist + int'($urandom_range(0, 200)) - 100;
         endcase
         if (sweep_dist < 0) sweep_dist = 0;
         if (sweep_dist > 65535) sweep_dist = 65535;
         if ($urandom_range(0, 3) == 0) q = int'($urandom_range(0, 63));
         else q = int'($urandom_range(regs_now.min_quality, 63));
         cut = ($urandom_range(0, 24) == 0) ? int'($urandom_range(1, 4)) : 5;
         send_packet(j == 0, 6'(q), 15'(raw), 16'(sweep_dist), cut);
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      int p;
      int unsigned phase_end;
      cfg_type c;

      regs_now = '{RST_MIN_DISTANCE, RST_MIN_QUALITY, RST_CLUSTER_DIST, RST_CLUSTER_ANGLE,
                   RST_CLUSTER_POINTS, RST_BACKWARD_LIMIT, RST_FORWARD_LIMIT};
      foreach (window_q[i]) window_q[i] = '0;
      lock_angle = '0;
      lock_armed = 1'b0;
      best_q     = '{15'd0, NO_DISTANCE, 6'd0, 1'b0};
      obj_dist   = '0;
      obj_angle  = '0;
      run_count  = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed packets under the reset register values
      foreach (dir_rows[i]) begin
         send_packet(dir_rows[i].start, dir_rows[i].qual, dir_rows[i].raw_angle,
                     dir_rows[i].distance, 5);
         if (dir_rows[i].typed) begin
            drain();
            check_nearest(dir_rows[i].want, last_data, last_user);
         end
      end
      drain();

      // random phases: all-zero registers, maximum values with half-turn angle fields, then mixed settings
      for (p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            c = '0;
         end else if (p == 1) begin
            c = '{16'hFFFF, 6'h3F, 16'hFFFF, 14'd11520, 8'hFF, 14'd11520, 14'd11520};
         end else begin
            c.min_distance               = 16'(pick_setting(1500, 65535));
            c.min_quality                = 6'(pick_setting(25, 63));
            c.cluster_distance_tolerance = 16'(pick_setting(600, 65535));
            c.cluster_angle_tolerance    = 14'(pick_setting(600, 16383));
            c.cluster_min_points         = 8'(pick_setting(5, 255));
            c.backward_step_limit        = 14'(pick_setting(300, 16383));
            c.forward_step_limit         = 14'(pick_setting(1500, 16383));
         end
         load_regs(c);
         gaps_on = (p != PHASES - 1);   // last phase runs flat out
         // pressure: receiver stops while back-to-back starts pile up reports
         if (p == PRESSURE_PHASE) hold_req = 1'b1;
         phase_end = bytes_sent + RANDOM_BYTES / PHASES;
         while (bytes_sent < phase_end) begin
            if (p == PRESSURE_PHASE) run_revolution(int'($urandom_range(0, 1)));
            else run_revolution(int'($urandom_range(2, 8)));
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lsnc_pkg.sv
rtl/lsnc_csr.sv
rtl/lsnc_packet.sv
rtl/lsnc_tracker.sv
rtl/lidar_scan_nearest_cluster.sv
verif/tb_top.sv
